FILE: hw/rtl/rsi_pkg.sv
// shared widths, register indexes and constants of the ray / sphere intersect pipeline
`timescale 1ns / 1ps
package rsi_pkg;

    localparam int COORD_W = 32;   // signed Q16.16 coordinate
    localparam int DIR_W   = 18;   // signed Q2.16 direction, +-1.0
    localparam int RAD_W   = 31;   // unsigned Q15.16 radius
    localparam int CFG_IW  = 2;    // register index width
    localparam int CFG_DW  = 32;   // widest register

    localparam int IN_TDATA_W  = 152;  // 150 bits of fields, padded to bytes
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 1;

    localparam int V_W   = 33;     // o - c
    localparam int P_W   = 51;     // d * v
    localparam int H_W   = 53;     // d . v, Q.32
    localparam int SQ_W  = 65;     // one |v| component squared
    localparam int S_W   = 67;     // |v|^2, Q.32
    localparam int RR_W  = 62;     // r^2, Q.32
    localparam int AH_W  = 51;     // |h|
    localparam int AH2_W = 102;    // h^2, Q.64
    localparam int D_W   = 104;    // discriminant, Q.64
    localparam int RT_W  = 52;     // floor(sqrt(D)), Q.32
    localparam int REM_W = 56;     // square root remainder
    localparam int T_W   = 55;     // root in Q.32, signed

    localparam logic [COORD_W-1:0] MISS_DISTANCE = 32'hFFFF_0000;  // -1.0
    localparam logic [COORD_W-1:0] MAX_DISTANCE  = 32'h7FFF_FFFF;
    localparam logic [RAD_W-1:0]   RADIUS_RESET  = 31'd65536;      // 1.0

    typedef enum logic [CFG_IW-1:0] {
        CFG_CENTER_X      = 2'd0,
        CFG_CENTER_Y      = 2'd1,
        CFG_CENTER_Z      = 2'd2,
        CFG_SPHERE_RADIUS = 2'd3
    } t_cfg_index;

endpackage

FILE: hw/rtl/ray_sphere_intersect.sv
// ray / sphere intersection pipeline, one ray per cycle while not stalled
`timescale 1ns / 1ps
//
// channel    dir  handshake                          payload
// s_axis     in   i_s_axis_tvalid / o_s_axis_tready  ray origin and direction
// m_axis     out  o_m_axis_tvalid / i_m_axis_tready  hit distance, hit flag
// cfg        in   i_cfg_wr_en                        sphere center and radius
//
// one ray enters and one result leaves per cycle while the skid register is empty; 63
// register stages, among them the 52 stages of the bit-per-stage square root and the
// multiply stages
// reset clears valid bits and loads center 0 and radius 1.0; no clearing pass
// a result not taken goes to a one-entry skid register; while it is full the whole
// pipeline holds and o_s_axis_tready is low, so nothing is dropped or repeated
//
module ray_sphere_intersect #(
    parameter int MIN_DISTANCE_LSB = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [rsi_pkg::CFG_IW-1:0]      i_cfg_index,
    input  logic [rsi_pkg::CFG_DW-1:0]      i_cfg_data,
    // rays in
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, 2 zero bits
    input  logic [rsi_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // results out
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // hit_distance
    output logic [rsi_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // hit
    output logic [rsi_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser
);
    import rsi_pkg::*;

    localparam int NS   = RT_W;          // one root bit per stage
    localparam int TQ_W = T_W - 1 - 16;  // nonnegative root in Q22.16
    localparam logic [TQ_W-1:0] MIN_T = TQ_W'(MIN_DISTANCE_LSB);

    // ---------------- configuration registers ----------------
    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic [RAD_W-1:0]          r_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= RADIUS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CENTER_X:      r_cx  <= i_cfg_data;
                CFG_CENTER_Y:      r_cy  <= i_cfg_data;
                CFG_CENTER_Z:      r_cz  <= i_cfg_data;
                CFG_SPHERE_RADIUS: r_rad <= i_cfg_data[RAD_W-1:0];
                default:           r_rad <= r_rad;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic r_ov, r_sv;                    // output and skid valid
    logic en;                            // whole pipeline advances
    logic in_fire;

    assign en              = !r_sv;
    assign o_s_axis_tready = en;
    assign in_fire         = i_s_axis_tvalid && en;

    // unpack the ray
    logic signed [COORD_W-1:0] ox, oy, oz;
    logic signed [DIR_W-1:0]   dx, dy, dz;
    assign ox = i_s_axis_tdata[31:0];
    assign oy = i_s_axis_tdata[63:32];
    assign oz = i_s_axis_tdata[95:64];
    assign dx = i_s_axis_tdata[113:96];
    assign dy = i_s_axis_tdata[131:114];
    assign dz = i_s_axis_tdata[149:132];

    // stage valid bits
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r9_v, r_fin_v;
    logic r_q_v [0:NS];

    // ---------------- stage 1: v = o - c ----------------
    logic signed [V_W-1:0]   r1_vx, r1_vy, r1_vz;
    logic signed [DIR_W-1:0] r1_dx, r1_dy, r1_dz;
    logic [RAD_W-1:0]        r1_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_vx  <= {ox[COORD_W-1], ox} - {r_cx[COORD_W-1], r_cx};
            r1_vy  <= {oy[COORD_W-1], oy} - {r_cy[COORD_W-1], r_cy};
            r1_vz  <= {oz[COORD_W-1], oz} - {r_cz[COORD_W-1], r_cz};
            r1_dx  <= dx;
            r1_dy  <= dy;
            r1_dz  <= dz;
            r1_rad <= r_rad;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [P_W-1:0]     r2_px, r2_py, r2_pz;
    logic [SQ_W-1:0]           r2_sx, r2_sy, r2_sz;
    logic [RR_W-1:0]           r2_rr;
    logic signed [2*V_W-1:0]   sqx, sqy, sqz;

    always_comb begin
        sqx = r1_vx * r1_vx;
        sqy = r1_vy * r1_vy;
        sqz = r1_vz * r1_vz;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_px <= P_W'(r1_dx) * P_W'(r1_vx);
            r2_py <= P_W'(r1_dy) * P_W'(r1_vy);
            r2_pz <= P_W'(r1_dz) * P_W'(r1_vz);
            r2_sx <= sqx[SQ_W-1:0];
            r2_sy <= sqy[SQ_W-1:0];
            r2_sz <= sqz[SQ_W-1:0];
            r2_rr <= RR_W'(r1_rad) * RR_W'(r1_rad);
        end
    end

    // ---------------- stage 3: h = d.v, S = |v|^2 ----------------
    logic signed [H_W-1:0] r3_h;
    logic [S_W-1:0]        r3_s;
    logic [RR_W-1:0]       r3_rr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_h  <= H_W'(r2_px) + H_W'(r2_py) + H_W'(r2_pz);
            r3_s  <= S_W'(r2_sx) + S_W'(r2_sy) + S_W'(r2_sz);
            r3_rr <= r2_rr;
        end
    end

    // ---------------- stage 4: |h| ----------------
    logic signed [H_W-1:0] r4_h;
    logic [AH_W-1:0]       r4_ah;
    logic [S_W-1:0]        r4_s;
    logic [RR_W-1:0]       r4_rr;
    logic signed [H_W-1:0] abs_h;

    // |h| stays below 3 * 2^49, so it fits the narrower word
    assign abs_h = r3_h[H_W-1] ? -r3_h : r3_h;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_h  <= r3_h;
            r4_ah <= abs_h[AH_W-1:0];
            r4_s  <= r3_s;
            r4_rr <= r3_rr;
        end
    end

    // ---------------- stage 5: h^2 partial products ----------------
    localparam int AL_W = 26;
    localparam int AU_W = AH_W - AL_W;

    logic [2*AU_W-1:0]      r5_p11;
    logic [AU_W+AL_W-1:0]   r5_p10;
    logic [2*AL_W-1:0]      r5_p00;
    logic signed [H_W-1:0]  r5_h;
    logic [S_W-1:0]         r5_s;
    logic [RR_W-1:0]        r5_rr;
    logic [AU_W-1:0]        a_hi;
    logic [AL_W-1:0]        a_lo;

    assign a_hi = r4_ah[AH_W-1:AL_W];
    assign a_lo = r4_ah[AL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_p11 <= (2*AU_W)'(a_hi) * (2*AU_W)'(a_hi);
            r5_p10 <= (AU_W+AL_W)'(a_hi) * (AU_W+AL_W)'(a_lo);
            r5_p00 <= (2*AL_W)'(a_lo) * (2*AL_W)'(a_lo);
            r5_h   <= r4_h;
            r5_s   <= r4_s;
            r5_rr  <= r4_rr;
        end
    end

    // ---------------- stage 6: h^2 ----------------
    logic [AH2_W-1:0]      r6_ah2;
    logic signed [H_W-1:0] r6_h;
    logic [S_W-1:0]        r6_s;
    logic [RR_W-1:0]       r6_rr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ah2 <= (AH2_W'(r5_p11) << (2*AL_W)) + (AH2_W'(r5_p10) << (AL_W+1))
                    + AH2_W'(r5_p00);
            r6_h   <= r5_h;
            r6_s   <= r5_s;
            r6_rr  <= r5_rr;
        end
    end

    // ---------------- stage 7: positive and negative terms ----------------
    logic [D_W-1:0]        r7_pos, r7_neg;
    logic signed [H_W-1:0] r7_h;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_pos <= D_W'(r6_ah2) + (D_W'(r6_rr) << 32);
            r7_neg <= D_W'(r6_s) << 32;
            r7_h   <= r6_h;
        end
    end

    // ---------------- stage 8 and square root stages ----------------
    // q[0] holds the discriminant; each stage settles one root bit
    logic [REM_W-1:0]      r_q_rem  [0:NS];
    logic [RT_W-1:0]       r_q_root [0:NS];
    logic [D_W-1:0]        r_q_rad  [0:NS];
    logic signed [H_W-1:0] r_q_h    [0:NS];
    logic                  r_q_miss [0:NS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_rem[0]  <= '0;
            r_q_root[0] <= '0;
            r_q_rad[0]  <= r7_pos - r7_neg;
            r_q_miss[0] <= r7_pos < r7_neg;  // negative discriminant
            r_q_h[0]    <= r7_h;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        logic [REM_W-1:0] pre, trial;
        assign pre   = {r_q_rem[k][REM_W-3:0], r_q_rad[k][D_W-1 -: 2]};
        assign trial = {{(REM_W-RT_W-2){1'b0}}, r_q_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (pre >= trial) begin
                    r_q_rem[k+1]  <= pre - trial;
                    r_q_root[k+1] <= {r_q_root[k][RT_W-2:0], 1'b1};
                end else begin
                    r_q_rem[k+1]  <= pre;
                    r_q_root[k+1] <= {r_q_root[k][RT_W-2:0], 1'b0};
                end
                r_q_rad[k+1]  <= r_q_rad[k] << 2;
                r_q_miss[k+1] <= r_q_miss[k];
                r_q_h[k+1]    <= r_q_h[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_v[k+1] <= 1'b0;
            end else if (en) begin
                r_q_v[k+1] <= r_q_v[k];
            end
        end
    end

    // ---------------- stage 9: both roots ----------------
    logic signed [T_W-1:0] r9_t0, r9_t1;
    logic                  r9_miss;
    logic signed [T_W-1:0] neg_h, sq;

    assign neg_h = -T_W'(r_q_h[NS]);
    assign sq    = T_W'(r_q_root[NS]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_t0   <= neg_h - sq;
            r9_t1   <= neg_h + sq;
            r9_miss <= r_q_miss[NS];
        end
    end

    // ---------------- stage 10: pick the nearer root past epsilon ----------------
    logic [TQ_W-1:0]    tq0, tq1;
    logic               ok0, ok1;
    logic               n_hit;
    logic [COORD_W-1:0] n_dist;
    logic               r_fin_hit;
    logic [COORD_W-1:0] r_fin_dist;

    function automatic logic [COORD_W-1:0] sat_t(input logic [TQ_W-1:0] t);
        return (t[TQ_W-1:COORD_W-1] != '0) ? MAX_DISTANCE : COORD_W'(t);
    endfunction

    always_comb begin
        tq0 = r9_t0[T_W-2:16];
        tq1 = r9_t1[T_W-2:16];
        ok0 = !r9_t0[T_W-1] && (tq0 >= MIN_T);
        ok1 = !r9_t1[T_W-1] && (tq1 >= MIN_T);
        n_hit  = 1'b0;
        n_dist = MISS_DISTANCE;
        priority if (r9_miss) begin
            n_hit = 1'b0;
        end else if (ok0) begin
            n_hit  = 1'b1;
            n_dist = sat_t(tq0);
        end else if (ok1) begin
            n_hit  = 1'b1;
            n_dist = sat_t(tq1);
        end else begin
            // both roots behind the origin or inside epsilon
            n_hit  = 1'b0;
            n_dist = MISS_DISTANCE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin_hit  <= n_hit;
            r_fin_dist <= n_dist;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            r5_v     <= 1'b0;
            r6_v     <= 1'b0;
            r7_v     <= 1'b0;
            r_q_v[0] <= 1'b0;
            r9_v     <= 1'b0;
            r_fin_v  <= 1'b0;
        end else if (en) begin
            r1_v     <= in_fire;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r4_v     <= r3_v;
            r5_v     <= r4_v;
            r6_v     <= r5_v;
            r7_v     <= r6_v;
            r_q_v[0] <= r7_v;
            r9_v     <= r_q_v[NS];
            r_fin_v  <= r9_v;
        end
    end

    // ---------------- output register and skid ----------------
    logic               r_o_hit, r_s_hit;
    logic [COORD_W-1:0] r_o_dist, r_s_dist;
    logic               take;
    logic               push;

    assign take = r_ov && i_m_axis_tready;
    assign push = en && r_fin_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (r_sv) begin
                if (take) begin
                    r_sv <= 1'b0;
                end
            end else if (push) begin
                if (r_ov && !take) begin
                    r_sv <= 1'b1;
                end else begin
                    r_ov <= 1'b1;
                end
            end else if (take) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) begin
                r_o_hit  <= r_s_hit;
                r_o_dist <= r_s_dist;
            end
        end else if (push) begin
            if (r_ov && !take) begin
                r_s_hit  <= r_fin_hit;
                r_s_dist <= r_fin_dist;
            end else begin
                r_o_hit  <= r_fin_hit;
                r_o_dist <= r_fin_dist;
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_o_dist;
    assign o_m_axis_tuser  = r_o_hit;

    // ---------------- assertions ----------------
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a result while the output register is empty");

    a_hit_past_eps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_hit) |-> (!r_o_dist[COORD_W-1]
            && (TQ_W'(r_o_dist) >= MIN_T)))
        else $error("hit distance below the minimum distance");

    a_miss_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_o_hit) |-> (r_o_dist == MISS_DISTANCE))
        else $error("miss without the miss distance");

    a_skid_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && i_m_axis_tready) |=> (r_ov && !r_sv))
        else $error("skid entry not moved to the output register");

endmodule

FILE: tb/sv/tb_ray_sphere_intersect.sv
// self-checking testbench of the ray / sphere intersect pipeline
`timescale 1ns / 1ps

module tb_ray_sphere_intersect;
    import rsi_pkg::*;

    localparam int LATENCY    = 63;
    localparam int DRAIN_WAIT = LATENCY + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_RAYS = 275;   // six phases, about 1650 rays
    localparam int STALL_LEN   = 300;  // long receiver hold-off
    localparam int MIN_DIST    = 7;
    localparam logic [DIR_W-1:0] DIR_ONE  = 18'h10000;   // +1.0
    localparam logic [DIR_W-1:0] DIR_MONE = 18'h30000;   // -1.0

    typedef struct packed {
        logic [COORD_W-1:0] ox, oy, oz;
        logic [DIR_W-1:0]   dx, dy, dz;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] distance;
    } hit_t;

    typedef struct {
        ray_t r;
        bit   typed;      // expected result written in the row
        hit_t want;
    } row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_IW-1:0]      i_cfg_index;
    logic [CFG_DW-1:0]      i_cfg_data;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, 2 zero bits
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // hit_distance
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // hit
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    ray_sphere_intersect i_dut (.*);

    // sphere as the testbench believes it is programmed
    logic [COORD_W-1:0] ctr_x, ctr_y, ctr_z;
    logic [RAD_W-1:0]   rad;

    hit_t   pending_hits[$];
    row_t   dir_tab[$];
    int     n_err;
    int     n_cycles;
    bit     idle_en;      // random idling on both sides
    bit     stall_req;    // ask the receiver for one long hold-off
    int     rdy_gap;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // expected hit / distance of one ray against the current sphere
    function automatic hit_t trace_sphere(ray_t r);
        logic signed [127:0] vx, vy, vz, h, pos, neg, dsc, t, tq;
        logic signed [127:0] rr;
        logic [127:0]        root, cand;
        hit_t                res;
        res.hit      = 1'b0;
        res.distance = MISS_DISTANCE;
        vx = $signed(r.ox) - $signed(ctr_x);
        vy = $signed(r.oy) - $signed(ctr_y);
        vz = $signed(r.oz) - $signed(ctr_z);
        h  = $signed(r.dx) * vx + $signed(r.dy) * vy + $signed(r.dz) * vz;
        rr = {97'b0, rad};
        pos = h * h + ((rr * rr) <<< 32);
        neg = (vx * vx + vy * vy + vz * vz) <<< 32;
        if (pos < neg) return res;
        dsc  = pos - neg;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= dsc) root = cand;
        end
        // nearer root first, then the far one
        for (int k = 0; k < 2; k++) begin
            t = (k == 0) ? -h - $signed(root) : -h + $signed(root);
            if (t >= 0) begin
                tq = t >>> 16;
                if (tq >= MIN_DIST) begin
                    res.hit      = 1'b1;
                    res.distance = (tq > MAX_DISTANCE) ? MAX_DISTANCE : tq[31:0];
                    return res;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, n_cycles);
        n_err++;
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        case (idx)
            CFG_CENTER_X:      ctr_x = val;
            CFG_CENTER_Y:      ctr_y = val;
            CFG_CENTER_Z:      ctr_z = val;
            CFG_SPHERE_RADIUS: rad   = val[RAD_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic load_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [31:0] r);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_SPHERE_RADIUS, r);
    endtask

    // block idle: every result back and the pipe flushed
    task automatic wait_drained();
        wait (pending_hits.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // one ray transfer; the expectation is queued once the block takes it
    task automatic send_ray(ray_t r, bit typed, hit_t want);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {2'b00, r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_hits.push_back(typed ? want : trace_sphere(r));
    endtask

    function automatic logic [DIR_W-1:0] rand_dir();
        return DIR_W'($urandom_range(0, 131072) - 65536);
    endfunction

    // mostly rays starting near the sphere, the rest anywhere
    function automatic ray_t rand_ray();
        ray_t r;
        int   span;
        int   axis;
        span = (rad > 31'h0008_0000) ? 32'h0010_0000 : 2 * int'(rad) + 32'h0004_0000;
        if ($urandom_range(0, 9) < 7) begin
            r.ox = ctr_x + 32'($urandom_range(0, 2 * span) - span);
            r.oy = ctr_y + 32'($urandom_range(0, 2 * span) - span);
            r.oz = ctr_z + 32'($urandom_range(0, 2 * span) - span);
        end else begin
            r.ox = $urandom;
            r.oy = $urandom;
            r.oz = $urandom;
        end
        if ($urandom_range(0, 1)) begin
            axis = $urandom_range(0, 2);
            r.dx = (axis == 0) ? ($urandom_range(0, 1) ? DIR_ONE : DIR_MONE) : '0;
            r.dy = (axis == 1) ? ($urandom_range(0, 1) ? DIR_ONE : DIR_MONE) : '0;
            r.dz = (axis == 2) ? ($urandom_range(0, 1) ? DIR_ONE : DIR_MONE) : '0;
        end else begin
            r.dx = rand_dir();
            r.dy = rand_dir();
            r.dz = rand_dir();
        end
        return r;
    endfunction

    task automatic add_row(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [17:0] dx, logic [17:0] dy, logic [17:0] dz,
                           bit typed, logic h, logic [31:0] d);
        row_t row;
        row.r     = '{ox, oy, oz, dx, dy, dz};
        row.typed = typed;
        row.want  = '{h, d};
        dir_tab.push_back(row);
    endtask

    // receiver: random ready bursts, plus one long hold-off on request
    initial begin
        i_m_axis_tready = 1'b0;
        rdy_gap = 0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                rdy_gap   = STALL_LEN;
            end
            if (rdy_gap > 0) begin
                i_m_axis_tready = 1'b0;
                rdy_gap--;
            end else begin
                i_m_axis_tready = 1'b1;
                if (idle_en && $urandom_range(0, 4) == 0) rdy_gap = $urandom_range(1, 3);
            end
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        hit_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected result", 32'h0, o_m_axis_tdata);
            end else begin
                want = pending_hits.pop_front();
                if (o_m_axis_tuser[0] !== want.hit)
                    report_mismatch("hit", 32'(want.hit), 32'(o_m_axis_tuser[0]));
                if (o_m_axis_tdata !== want.distance)
                    report_mismatch("hit_distance", want.distance, o_m_axis_tdata);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_ray_sphere_intersect NOT OK");
            $finish;
        end
    end

    initial begin
        hit_t none;
        n_err           = 0;
        n_cycles        = 0;
        idle_en         = 1'b1;
        stall_req       = 1'b0;
        none            = '0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        // reset values of the sphere: center 0, radius 1.0
        ctr_x = '0;
        ctr_y = '0;
        ctr_z = '0;
        rad   = RADIUS_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rays against the unit sphere at the origin
        add_row(0, 0, 0, DIR_ONE, 0, 0, 1, 1'b1, 32'h0001_0000);           // from center
        add_row(32'hFFFB_0000, 0, 0, DIR_ONE, 0, 0, 1, 1'b1, 32'h0004_0000); // from outside
        add_row(32'hFFFB_0000, 0, 0, DIR_MONE, 0, 0, 1, 1'b0, MISS_DISTANCE); // behind origin
        add_row(0, 32'h0005_0000, 0, DIR_ONE, 0, 0, 1, 1'b0, MISS_DISTANCE); // negative disc
        add_row(32'hFFFB_0000, 32'h0001_0000, 0, DIR_ONE, 0, 0, 1, 1'b1,
                32'h0005_0000);                                                // tangent
        add_row(32'h0000_FFF9, 0, 0, DIR_ONE, 0, 0, 1, 1'b1, 32'd7);         // at epsilon
        add_row(32'h0000_FFFA, 0, 0, DIR_ONE, 0, 0, 1, 1'b0, MISS_DISTANCE); // below epsilon
        add_row(0, 0, 0, 0, 0, 0, 1, 1'b1, 32'h0001_0000);                   // zero direction
        add_row(32'h0003_0000, 0, 0, 0, 0, 0, 1, 1'b0, MISS_DISTANCE);       // zero dir, outside
        add_row(0, 32'hFFFD_0000, 0, 0, DIR_ONE, 0, 0, 0, 0);
        add_row(0, 0, 32'h0002_0000, 0, 0, DIR_MONE, 0, 0, 0);
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, DIR_MONE, DIR_MONE, DIR_MONE,
                0, 0, 0);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, DIR_ONE, DIR_ONE, DIR_ONE,
                0, 0, 0);
        add_row(32'h0000_8000, 32'h0000_4000, 0, 18'h0B505, 18'h34AFB, 0, 0, 0, 0);
        add_row(32'h7FFF_FFFF, 0, 32'h8000_0000, 18'h1FFFF, 18'h20000, 18'h0FFFF, 0, 0, 0);
        foreach (dir_tab[i]) send_ray(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].want);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait_drained();

        // random phases, each under its own sphere
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_sphere(32'h0003_0000, 32'hFFFE_8000, 32'h0000_4000, 32'h0002_0000);
                1: load_sphere(0, 0, 0, 32'h7FFF_FFFF);                      // saturation
                2: load_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000);
                3: load_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
                4: load_sphere($urandom, $urandom, $urandom, $urandom_range(1, 32'h0040_0000));
                default: load_sphere($urandom_range(0, 32'h000F_0000), 32'hFFF0_0000, 0,
                                     32'h0003_8000);
            endcase
            idle_en = (ph != 5);   // last phase runs at full rate
            for (int n = 0; n < PHASE_RAYS; n++) begin
                if (ph == 2 && n == 40) stall_req = 1'b1;
                send_ray(rand_ray(), 1'b0, none);
            end
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            wait_drained();
        end

        if (n_err == 0) begin
            $display("tb_ray_sphere_intersect OK");
        end else begin
            $display("tb_ray_sphere_intersect NOT OK");
        end
        $finish;
    end

endmodule
